// ----- rtl/core/two_square_cowbell_voice_assert.svh -----
// Assertion macros for the cowbell voice.
// Clock aclk and active-low reset aresetn are taken from the enclosing module.
`ifndef TWO_SQUARE_COWBELL_VOICE_ASSERT_SVH
`define TWO_SQUARE_COWBELL_VOICE_ASSERT_SVH
`ifndef ASSERT_OFF
`define TSCV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define TSCV_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);
`else
`define TSCV_ASSERT(label, prop, msg)
`define TSCV_ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ----- rtl/core/tscv_pkg.sv -----
package tscv_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int VEL_W       = 7;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_LO,
        CFG_STEP_HI,
        CFG_DECAY,
        CFG_B0,
        CFG_A1,
        CFG_A2,
        CFG_LEVEL
    } cfg_reg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_NOTE,
        OP_CHECK,
        OP_RAW,
        OP_MUL_B0,
        OP_MUL_A1,
        OP_MUL_A2,
        OP_MUL_GAIN,
        OP_FILT,
        OP_MUL_Y,
        OP_MUL_ENV,
        OP_ENV
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic sounding;
        logic env_low;
    } dp_status_t;

endpackage

// ----- rtl/core/tscv_dp.sv -----
module tscv_dp
    import tscv_pkg::*;
#(
    parameter int unsigned PHASE_BITS    = 24,
    parameter int unsigned SILENCE_LEVEL = 839
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_note,
    input  logic [VEL_W-1:0]      in_vel,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam int STEP_W  = 23;
    localparam int ENV_W   = 24;
    localparam int COEF_W  = 24;
    localparam int LEVEL_W = 16;
    localparam int GAIN_W  = VEL_W + LEVEL_W;
    localparam int MUL_W   = 25;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int SUM_W   = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;
    localparam int PAD_W   = M_TDATA_W - SAMPLE_BITS - 1;

    localparam logic [ENV_W-1:0] ENV_ONE = 24'h800000;
    localparam logic [ENV_W-1:0] SILENCE = ENV_W'(SILENCE_LEVEL);
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(S_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(S_MIN);
    localparam logic signed [ACC_W-1:0] RND_Y  = ACC_W'(64'sd1 <<< 21);
    localparam logic signed [ACC_W-1:0] RND_O  = ACC_W'(64'sd1 <<< 22);

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [SAMPLE_BITS-1:0] r;
        if (v > SAT_HI) begin
            r = S_MAX;
        end else if (v < SAT_LO) begin
            r = S_MIN;
        end else begin
            r = v[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

    logic [STEP_W-1:0]              step_lo_reg;
    logic [STEP_W-1:0]              step_hi_reg;
    logic [ENV_W-1:0]               decay_reg;
    logic signed [COEF_W-1:0]       b0_reg;
    logic signed [COEF_W-1:0]       a1_reg;
    logic signed [COEF_W-1:0]       a2_reg;
    logic [LEVEL_W-1:0]             level_reg;

    logic [PHASE_BITS-1:0]          phase_a_reg;
    logic [PHASE_BITS-1:0]          phase_b_reg;
    logic [ENV_W-1:0]               env_reg;
    logic                           sounding_reg;
    logic [VEL_W-1:0]               vel_reg;
    logic signed [SAMPLE_BITS-1:0]  x1_reg;
    logic signed [SAMPLE_BITS-1:0]  x2_reg;
    logic signed [SAMPLE_BITS-1:0]  y1_reg;
    logic signed [SAMPLE_BITS-1:0]  y2_reg;

    logic signed [SAMPLE_BITS-1:0]  raw_reg;
    logic signed [MUL_W-1:0]        diff_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [SAMPLE_BITS-1:0]  y_reg;
    logic [GAIN_W-1:0]              gain_reg;
    logic signed [SAMPLE_BITS-1:0]  res_sample_reg;
    logic                           res_active_reg;
    logic [M_TDATA_W-1:0]           m_tdata_reg;

    logic [SUM_W-1:0]               sum_a;
    logic [SUM_W-1:0]               sum_b;
    logic signed [MUL_W-1:0]        neg_env;
    logic signed [SAMPLE_BITS-1:0]  raw_next;
    logic signed [MUL_W-1:0]        mul_a;
    logic signed [MUL_W-1:0]        mul_b;
    logic                           mul_en;
    logic signed [ACC_W-1:0]        y_rnd;
    logic signed [ACC_W-1:0]        o_rnd;
    logic signed [SAMPLE_BITS-1:0]  y_next;
    logic signed [SAMPLE_BITS-1:0]  o_next;

    assign sum_a = SUM_W'(phase_a_reg) + SUM_W'(step_lo_reg);
    assign sum_b = SUM_W'(phase_b_reg) + SUM_W'(step_hi_reg);

    // square mix of +1, 0 or -1 times the envelope, saturated
    assign neg_env = -$signed({1'b0, env_reg});
    always_comb begin
        if (!phase_a_reg[PHASE_BITS-1] && !phase_b_reg[PHASE_BITS-1]) begin
            raw_next = (env_reg > ENV_W'(S_MAX)) ? S_MAX : $signed(env_reg);
        end else if (phase_a_reg[PHASE_BITS-1] && phase_b_reg[PHASE_BITS-1]) begin
            raw_next = (env_reg > ENV_ONE) ? S_MIN : neg_env[SAMPLE_BITS-1:0];
        end else begin
            raw_next = '0;
        end
    end

    always_comb begin
        mul_en = 1'b1;
        case (cmd.op)
            OP_MUL_B0: begin
                mul_a = MUL_W'(b0_reg);
                mul_b = diff_reg;
            end
            OP_MUL_A1: begin
                mul_a = MUL_W'(a1_reg);
                mul_b = MUL_W'(y1_reg);
            end
            OP_MUL_A2: begin
                mul_a = MUL_W'(a2_reg);
                mul_b = MUL_W'(y2_reg);
            end
            OP_MUL_GAIN: begin
                mul_a = $signed({{(MUL_W-VEL_W){1'b0}}, vel_reg});
                mul_b = $signed({{(MUL_W-LEVEL_W){1'b0}}, level_reg});
            end
            OP_MUL_Y: begin
                mul_a = MUL_W'(y_reg);
                mul_b = $signed({{(MUL_W-GAIN_W){1'b0}}, gain_reg});
            end
            OP_MUL_ENV: begin
                mul_a = $signed({{(MUL_W-ENV_W){1'b0}}, env_reg});
                mul_b = $signed({{(MUL_W-ENV_W){1'b0}}, decay_reg});
            end
            default: begin
                mul_en = 1'b0;
                mul_a  = '0;
                mul_b  = '0;
            end
        endcase
    end

    assign y_rnd  = (acc_reg + RND_Y) >>> 22;
    assign o_rnd  = (ACC_W'(prod_reg) + RND_O) >>> 23;
    assign y_next = sat_sample(y_rnd);
    assign o_next = sat_sample(o_rnd);

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        case (cmd.op)
            OP_RAW: begin
                raw_reg  <= raw_next;
                diff_reg <= MUL_W'(raw_next) - MUL_W'(x2_reg);
            end
            OP_MUL_A1: acc_reg <= ACC_W'(prod_reg);
            OP_MUL_A2: acc_reg <= acc_reg - ACC_W'(prod_reg);
            OP_MUL_GAIN: acc_reg <= acc_reg - ACC_W'(prod_reg);
            OP_FILT: begin
                y_reg    <= y_next;
                gain_reg <= prod_reg[GAIN_W-1:0];
            end
            default: begin
            end
        endcase
        if (cmd.out_load) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, res_active_reg, res_sample_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_lo_reg    <= 23'd205435;
            step_hi_reg    <= 23'd304047;
            decay_reg      <= 24'd16773401;
            b0_reg         <= 24'sd79076;
            a1_reg         <= -24'sd8206107;
            a2_reg         <= 24'sd4036184;
            level_reg      <= 16'd45875;
            phase_a_reg    <= '0;
            phase_b_reg    <= '0;
            env_reg        <= '0;
            sounding_reg   <= 1'b0;
            vel_reg        <= '0;
            x1_reg         <= '0;
            x2_reg         <= '0;
            y1_reg         <= '0;
            y2_reg         <= '0;
            res_sample_reg <= '0;
            res_active_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_STEP_LO: step_lo_reg <= cfg_data[STEP_W-1:0];
                    CFG_STEP_HI: step_hi_reg <= cfg_data[STEP_W-1:0];
                    CFG_DECAY:   decay_reg   <= cfg_data;
                    CFG_B0:      b0_reg      <= $signed(cfg_data);
                    CFG_A1:      a1_reg      <= $signed(cfg_data);
                    CFG_A2:      a2_reg      <= $signed(cfg_data);
                    CFG_LEVEL:   level_reg   <= cfg_data[LEVEL_W-1:0];
                    default: begin
                    end
                endcase
            end
            case (cmd.op)
                OP_NOTE: begin
                    if (in_note && (in_vel != '0)) begin
                        sounding_reg <= 1'b1;
                        phase_a_reg  <= '0;
                        phase_b_reg  <= '0;
                        env_reg      <= ENV_ONE;
                        vel_reg      <= in_vel;
                    end
                end
                OP_CHECK: begin
                    if (!sounding_reg || status.env_low) begin
                        res_sample_reg <= '0;
                        res_active_reg <= 1'b0;
                    end
                    if (!sounding_reg) begin
                    end else if (status.env_low) begin
                        // silence: whole voice back to rest
                        sounding_reg <= 1'b0;
                        phase_a_reg  <= '0;
                        phase_b_reg  <= '0;
                        env_reg      <= '0;
                        vel_reg      <= '0;
                        x1_reg       <= '0;
                        x2_reg       <= '0;
                        y1_reg       <= '0;
                        y2_reg       <= '0;
                    end else begin
                        phase_a_reg <= sum_a[PHASE_BITS-1:0];
                        phase_b_reg <= sum_b[PHASE_BITS-1:0];
                    end
                end
                OP_FILT: begin
                    x2_reg <= x1_reg;
                    x1_reg <= raw_reg;
                    y2_reg <= y1_reg;
                    y1_reg <= y_next;
                end
                OP_MUL_ENV: begin
                    res_sample_reg <= o_next;
                    res_active_reg <= 1'b1;
                end
                OP_ENV: env_reg <= prod_reg[2*ENV_W-1:ENV_W];
                default: begin
                end
            endcase
        end
    end

    assign status.sounding = sounding_reg;
    assign status.env_low  = (env_reg < SILENCE);
    assign m_tdata         = m_tdata_reg;

endmodule

// ----- rtl/core/tscv_ctrl.sv -----
`include "two_square_cowbell_voice_assert.svh"

module tscv_ctrl
    import tscv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RAW,
        ST_MUL_B0,
        ST_MUL_A1,
        ST_MUL_A2,
        ST_MUL_GAIN,
        ST_FILT,
        ST_MUL_Y,
        ST_MUL_ENV,
        ST_ENV,
        ST_WRITE
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd.out_load = (state_reg == ST_WRITE) && (!m_tvalid_reg || m_tready);
        case (state_reg)
            ST_IDLE:     cmd.op = accept ? OP_NOTE : OP_NONE;
            ST_CHECK:    cmd.op = OP_CHECK;
            ST_RAW:      cmd.op = OP_RAW;
            ST_MUL_B0:   cmd.op = OP_MUL_B0;
            ST_MUL_A1:   cmd.op = OP_MUL_A1;
            ST_MUL_A2:   cmd.op = OP_MUL_A2;
            ST_MUL_GAIN: cmd.op = OP_MUL_GAIN;
            ST_FILT:     cmd.op = OP_FILT;
            ST_MUL_Y:    cmd.op = OP_MUL_Y;
            ST_MUL_ENV:  cmd.op = OP_MUL_ENV;
            ST_ENV:      cmd.op = OP_ENV;
            default:     cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (!status.sounding || status.env_low) begin
                        state_reg <= ST_WRITE;
                    end else begin
                        state_reg <= ST_RAW;
                    end
                end
                ST_RAW:      state_reg <= ST_MUL_B0;
                ST_MUL_B0:   state_reg <= ST_MUL_A1;
                ST_MUL_A1:   state_reg <= ST_MUL_A2;
                ST_MUL_A2:   state_reg <= ST_MUL_GAIN;
                ST_MUL_GAIN: state_reg <= ST_FILT;
                ST_FILT:     state_reg <= ST_MUL_Y;
                ST_MUL_Y:    state_reg <= ST_MUL_ENV;
                ST_MUL_ENV:  state_reg <= ST_ENV;
                ST_ENV:      state_reg <= ST_WRITE;
                ST_WRITE: begin
                    if (cmd.out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:     state_reg <= ST_IDLE;
            endcase
        end
    end

    `TSCV_ASSERT(a_accept_busy, (s_tvalid && s_tready) |=> !s_tready, "accepted while busy")
    `TSCV_ASSERT(a_load_valid, cmd.out_load |=> m_tvalid, "loaded word not presented")
    `TSCV_ASSERT(a_stall_hold, (state_reg == ST_WRITE && m_tvalid && !m_tready) |=> (state_reg == ST_WRITE), "result left while output stalled")

endmodule

// ----- rtl/core/two_square_cowbell_voice.sv -----
// Two-square cowbell voice. Each input word is one sample tick and yields exactly one
// output word. A sounding tick steps through ST_CHECK, ST_RAW, ST_MUL_B0, ST_MUL_A1,
// ST_MUL_A2, ST_MUL_GAIN, ST_FILT, ST_MUL_Y, ST_MUL_ENV and ST_ENV to ST_WRITE, where
// its result is loaded into the output register; one shared 25x25 multiplier forms six
// products in turn (filter b0, a1, a2, velocity times level, output gain, envelope
// decay). A tick on an idle voice, or the tick on which the envelope has fallen below
// the silence level, goes from ST_CHECK straight to ST_WRITE. The next word is taken
// on the clock after the previous one has reached the output register; a stalled
// output holds back at most one word. Configuration must be written only while no tick
// is in flight; the block itself does not enforce this.
module two_square_cowbell_voice
    import tscv_pkg::*;
#(
    parameter int unsigned PHASE_BITS    = 24,
    parameter int unsigned SILENCE_LEVEL = 839
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // note_on, strike_velocity[6:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // sample_out[23:0], voice_active, zero pad
);

    dp_cmd_t    cmd;
    dp_status_t status;

    tscv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tscv_dp #(
        .PHASE_BITS    (PHASE_BITS),
        .SILENCE_LEVEL (SILENCE_LEVEL)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_note   (s_tdata[0]),
        .in_vel    (s_tdata[VEL_W:1]),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- dv/testbench.sv -----
module testbench;
    import tscv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     PHASE_W      = 24;
    localparam int     SILENCE      = 839;
    localparam longint ENV_ONE      = 64'sd8388608;
    localparam longint SAMPLE_MAX   = 64'sd8388607;
    localparam longint SAMPLE_MIN   = -64'sd8388608;
    localparam longint ROUND_FILTER = 64'sd2097152;
    localparam longint ROUND_GAIN   = 64'sd4194304;
    localparam int     DRAIN_CYCLES = 24;
    localparam int     CYCLE_LIMIT  = 600000;
    localparam int     RANDOM_SETS  = 8;
    localparam int     TICKS_PER_SET = 105;

    typedef struct {
        logic signed [23:0] sample;
        logic               active;
    } voice_word_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;  // note_on, strike_velocity[6:0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // sample_out[23:0], voice_active, zero pad

    // settings held by the predictor
    logic [22:0] step_low  = 23'd205435;
    logic [22:0] step_high = 23'd304047;
    longint      decay     = 16773401;
    longint      coef_b0   = 79076;
    longint      coef_a1   = -8206107;
    longint      coef_a2   = 4036184;
    longint      level     = 45875;

    // voice state held by the predictor
    logic [PHASE_W-1:0] phase_lo = '0;
    logic [PHASE_W-1:0] phase_hi = '0;
    longint             env      = 0;
    bit                 voice_on = 1'b0;
    longint             held_vel = 0;
    longint             x1 = 0, x2 = 0, y1 = 0, y2 = 0;

    logic [7:0]  pending_ticks[$];
    voice_word_t expected_words[$];

    bit steady_run     = 1'b0;
    int send_gap       = 0;
    int stall_left     = 0;
    int error_count    = 0;
    int ticks_sent     = 0;
    int words_checked  = 0;
    int voiced_words   = 0;
    int silence_cuts   = 0;
    int register_writes = 0;

    two_square_cowbell_voice #(
        .PHASE_BITS   (PHASE_W),
        .SILENCE_LEVEL(SILENCE)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    function automatic longint clip(input longint v);
        return v > SAMPLE_MAX ? SAMPLE_MAX : (v < SAMPLE_MIN ? SAMPLE_MIN : v);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic voice_word_t cowbell_tick(input logic note, input logic [6:0] vel);
        voice_word_t res;
        int          mix;
        longint      raw, acc, y, o;
        res.sample = '0;
        res.active = 1'b0;
        if (note && vel != 0) begin
            voice_on = 1'b1;
            phase_lo = '0;
            phase_hi = '0;
            env      = ENV_ONE;
            held_vel = longint'(vel);
        end
        if (!voice_on) return res;
        if (env < SILENCE) begin
            phase_lo = '0;
            phase_hi = '0;
            env      = 0;
            voice_on = 1'b0;
            held_vel = 0;
            x1 = 0; x2 = 0; y1 = 0; y2 = 0;
            silence_cuts++;
            return res;
        end
        phase_lo = phase_lo + step_low;
        phase_hi = phase_hi + step_high;
        mix = (phase_lo[PHASE_W-1] ? -1 : 1) + (phase_hi[PHASE_W-1] ? -1 : 1);
        raw = clip(longint'(mix / 2) * env);
        acc = coef_b0 * raw - coef_b0 * x2 - coef_a1 * y1 - coef_a2 * y2;
        y = clip((acc + ROUND_FILTER) >>> 22);
        x2 = x1;
        x1 = raw;
        y2 = y1;
        y1 = y;
        o = clip((y * held_vel * level + ROUND_GAIN) >>> 23);
        env = (env * decay) >> 24;
        res.sample = o[23:0];
        res.active = 1'b1;
        return res;
    endfunction

    task automatic push_tick(input logic note, input logic [6:0] vel);
        pending_ticks.push_back({vel, note});
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [23:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_STEP_LO: step_low  = value[22:0];
            CFG_STEP_HI: step_high = value[22:0];
            CFG_DECAY:   decay     = longint'(value);
            CFG_B0:      coef_b0   = longint'(signed'(value));
            CFG_A1:      coef_a1   = longint'(signed'(value));
            CFG_A2:      coef_a2   = longint'(signed'(value));
            CFG_LEVEL:   level     = longint'(value[15:0]);
            default: ;
        endcase
        register_writes++;
    endtask

    task automatic apply_settings(input logic [23:0] s_lo, s_hi, dec, b0, a1, a2,
                                  input logic [23:0] lvl);
        write_register(CFG_STEP_LO, s_lo);
        write_register(CFG_STEP_HI, s_hi);
        write_register(CFG_DECAY, dec);
        write_register(CFG_B0, b0);
        write_register(CFG_A1, a1);
        write_register(CFG_A2, a2);
        write_register(CFG_LEVEL, lvl);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_ticks.size() != 0 || s_tvalid || expected_words.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // strikes followed by decaying tails, with some raw noise words mixed in
    task automatic queue_phrases(input int n);
        int added;
        int run;
        added = 0;
        while (added < n) begin
            if ($urandom_range(0, 9) == 0) begin
                pending_ticks.push_back(8'($urandom));
                added++;
            end else begin
                push_tick(1'b1, ($urandom_range(0, 19) == 0) ? 7'd0 : 7'($urandom_range(1, 127)));
                added++;
                run = $urandom_range(0, 80);
                for (int i = 0; i < run && added < n; i++) begin
                    push_tick(1'b0, 7'($urandom));
                    added++;
                end
            end
        end
    endtask

    // stimulus
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap != 0) begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_ticks.size() != 0) begin
                s_tdata  <= pending_ticks.pop_front();
                s_tvalid <= 1'b1;
                send_gap <= steady_run ? 0 : pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            expected_words.push_back(cowbell_tick(s_tdata[0], s_tdata[7:1]));
            ticks_sent++;
        end
    end

    // result side
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!steady_run && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        voice_word_t exp_word;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word %h", m_tdata);
                error_count++;
            end else begin
                exp_word = expected_words.pop_front();
                words_checked++;
                if (m_tdata[24]) voiced_words++;
                if (m_tdata[23:0] !== exp_word.sample) begin
                    $error("sample_out: expected %0d, got %0d",
                           exp_word.sample, $signed(m_tdata[23:0]));
                    error_count++;
                end
                if (m_tdata[24] !== exp_word.active) begin
                    $error("voice_active: expected %0d, got %0d",
                           exp_word.active, m_tdata[24]);
                    error_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("testbench: errors");
        $finish;
    end

    initial begin
        logic [23:0] s_lo, s_hi, dec, b0, a1, a2, lvl;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // defaults after reset: idle words, ignored strike, retrigger
        push_tick(1'b0, 7'd0);
        push_tick(1'b0, 7'd127);
        push_tick(1'b1, 7'd0);
        push_tick(1'b1, 7'd127);
        repeat (5) push_tick(1'b0, 7'd85);
        push_tick(1'b1, 7'd1);
        repeat (3) push_tick(1'b0, 7'd42);
        push_tick(1'b1, 7'd64);
        push_tick(1'b0, 7'd0);
        wait_idle();

        // envelope dies at once, coefficients at their limits
        apply_settings(24'd8388607, 24'd0, 24'd0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                       24'hFFFF);
        @(negedge aclk);
        push_tick(1'b1, 7'd127);
        push_tick(1'b0, 7'd127);
        push_tick(1'b0, 7'd0);
        push_tick(1'b1, 7'd99);
        push_tick(1'b1, 7'd127);
        push_tick(1'b0, 7'd1);
        push_tick(1'b0, 7'd0);
        wait_idle();

        for (int set = 0; set < RANDOM_SETS; set++) begin
            if (set == 0) begin
                s_lo = '0; s_hi = '0; dec = '0;
                b0 = 24'h800000; a1 = 24'h800000; a2 = 24'h800000; lvl = '0;
            end else if (set == 1) begin
                s_lo = 24'd8388607; s_hi = 24'd8388607; dec = 24'hFFFFFF;
                b0 = 24'h7FFFFF; a1 = 24'h7FFFFF; a2 = 24'h7FFFFF; lvl = 24'hFFFF;
            end else begin
                s_lo = 24'($urandom_range(0, 8388607));
                s_hi = 24'($urandom_range(0, 8388607));
                dec  = 24'($urandom_range(10000000, 16000000));
                if ($urandom_range(0, 1) == 0) begin
                    b0 = 24'($signed($urandom_range(0, 800000)) - 400000);
                    a1 = 24'(-8206107 + $signed($urandom_range(0, 200000)) - 100000);
                    a2 = 24'(4036184 + $signed($urandom_range(0, 200000)) - 100000);
                end else begin
                    b0 = 24'($urandom);
                    a1 = 24'($urandom);
                    a2 = 24'($urandom);
                end
                lvl = 24'($urandom_range(0, 65535));
            end
            apply_settings(s_lo, s_hi, dec, b0, a1, a2, lvl);
            steady_run = ($urandom_range(0, 3) == 0);
            @(negedge aclk);
            queue_phrases(TICKS_PER_SET);
            wait_idle();
        end

        steady_run = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_words.size() != 0) begin
            $error("%0d expected words never arrived", expected_words.size());
            error_count++;
        end
        $display("summary: %0d ticks, %0d words checked, %0d sounding, %0d silence cut-offs",
                 ticks_sent, words_checked, voiced_words, silence_cuts);
        $display("summary: %0d register writes over %0d settings",
                 register_writes, RANDOM_SETS + 1);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/tscv_pkg.sv
rtl/core/tscv_dp.sv
rtl/core/tscv_ctrl.sv
rtl/core/two_square_cowbell_voice.sv
dv/testbench.sv
